/* rtl/iac_pkg.sv */
// iac_pkg: shared types and constants for the imu axis calibration block
// holds payload structs, register indexes and fixed-point formats
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package iac_pkg;

    // field widths
    localparam int SAMPLE_W   = 16;
    localparam int COEFF_W    = 16;
    localparam int TEMP_W     = 16;
    localparam int CFG_W      = 48;
    localparam int PACK_W     = 3 * COEFF_W;
    localparam int NUM_AXES   = 3;

    // fixed-point formats
    localparam int SCALE_FRAC = COEFF_W - 2;
    localparam int TEMP_FRAC  = 8;
    localparam int TOTAL_FRAC = 32;
    localparam int P1_SH      = 2 * TEMP_FRAC;
    localparam int P2_SH      = TEMP_FRAC;

    // temperature delta and its powers
    localparam int DT_W       = TEMP_W + 1;
    localparam int DT2_W      = 2 * DT_W - 1;
    localparam int DT3_W      = 3 * DT_W - 2;
    localparam int DT3_LO     = 24;

    // saturation bounds
    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // reset values
    localparam logic [PACK_W-1:0]        SCALE_ONE    = PACK_W'(1) << SCALE_FRAC;
    localparam logic signed [TEMP_W-1:0] REF_TEMP_RST = 16'sd6400;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_SCALE_ROW_X = 3'd0,
        REG_SCALE_ROW_Y = 3'd1,
        REG_SCALE_ROW_Z = 3'd2,
        REG_OFFSET      = 3'd3,
        REG_POLY_LIN    = 3'd4,
        REG_POLY_SQ     = 3'd5,
        REG_POLY_CUBE   = 3'd6,
        REG_REF_TEMP    = 3'd7
    } t_reg_idx;

    // input transaction
    typedef struct packed {
        logic signed [TEMP_W-1:0]   temperature;
        logic signed [SAMPLE_W-1:0] sample_z;
        logic signed [SAMPLE_W-1:0] sample_y;
        logic signed [SAMPLE_W-1:0] sample_x;
    } t_cal_in;

    // output transaction
    typedef struct packed {
        logic                       saturated;
        logic signed [SAMPLE_W-1:0] corrected_z;
        logic signed [SAMPLE_W-1:0] corrected_y;
        logic signed [SAMPLE_W-1:0] corrected_x;
    } t_cal_out;

    // temperature delta powers shared by all lanes
    typedef struct packed {
        logic signed [DT_W-1:0]  dt;
        logic signed [DT2_W-1:0] dt2;
        logic signed [DT3_W-1:0] dt3;
    } t_temp_pows;

    // coefficients of one axis
    typedef struct packed {
        logic [PACK_W-1:0]         row;
        logic signed [COEFF_W-1:0] off;
        logic signed [COEFF_W-1:0] p1;
        logic signed [COEFF_W-1:0] p2;
        logic signed [COEFF_W-1:0] p3;
    } t_lane_coef;

    // result of one axis lane
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       clip;
    } t_lane_out;

endpackage
`default_nettype wire

/* rtl/iac_temp_pows.sv */
// iac_temp_pows: three-stage pipeline for dT, dT^2 and dT^3
// depends on iac_pkg
`timescale 1ns / 1ps
`default_nettype none
module iac_temp_pows (
    input  wire logic                              i_clk,
    input  wire logic signed [iac_pkg::TEMP_W-1:0] i_temp,
    input  wire logic signed [iac_pkg::TEMP_W-1:0] i_ref_temp,
    output iac_pkg::t_temp_pows                    o_pows
);
    import iac_pkg::*;

    logic signed [DT_W-1:0]        r_dt;
    logic signed [DT_W-1:0]        r_dt_d2;
    logic signed [DT_W-1:0]        r_dt_d3;
    logic signed [DT2_W-1:0]       r_dt2;
    logic signed [DT2_W-1:0]       r_dt2_d3;
    logic signed [DT3_W-1:0]       r_dt3;
    logic signed [2*DT_W-1:0]      w_sq;
    logic signed [DT2_W+DT_W-1:0]  w_cube;

    // square and cube, one multiplier per stage
    assign w_sq   = r_dt * r_dt;
    assign w_cube = r_dt2 * r_dt_d2;

    // delta, square, cube pipeline
    always_ff @(posedge i_clk) begin
        r_dt     <= DT_W'(i_temp) - DT_W'(i_ref_temp);
        r_dt_d2  <= r_dt;
        r_dt2    <= w_sq[DT2_W-1:0];
        r_dt_d3  <= r_dt_d2;
        r_dt2_d3 <= r_dt2;
        r_dt3    <= w_cube[DT3_W-1:0];
    end

    assign o_pows.dt  = r_dt_d3;
    assign o_pows.dt2 = r_dt2_d3;
    assign o_pows.dt3 = r_dt3;

endmodule
`default_nettype wire

/* rtl/iac_lane.sv */
// iac_lane: one axis of the correction, matrix row, offset and cubic,
// rounding and saturation in a seven-stage pipeline
// depends on iac_pkg; temperature powers come from iac_temp_pows
`timescale 1ns / 1ps
`default_nettype none
module iac_lane (
    input  wire logic                i_clk,
    input  iac_pkg::t_cal_in         i_smp,
    input  iac_pkg::t_lane_coef      i_coef,
    input  iac_pkg::t_temp_pows      i_pows,
    output iac_pkg::t_lane_out       o_res
);
    import iac_pkg::*;

    localparam int MUL_W  = COEFF_W + SAMPLE_W;
    localparam int ROW_W  = MUL_W + 2;
    localparam int ROW_SH = TOTAL_FRAC - SCALE_FRAC;
    localparam int Q1_W   = COEFF_W + DT_W;
    localparam int Q2_W   = COEFF_W + DT2_W;
    localparam int QLO_W  = COEFF_W + DT3_LO + 1;
    localparam int QHI_W  = COEFF_W + DT3_W - DT3_LO;
    localparam int T3_W   = COEFF_W + DT3_W;
    localparam int BIG_W  = (ROW_W + ROW_SH > T3_W) ? ROW_W + ROW_SH : T3_W;
    localparam int ACC_W  = BIG_W + 3;
    localparam int QW     = ACC_W - TOTAL_FRAC;
    localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (TOTAL_FRAC - 1);

    logic signed [SAMPLE_W-1:0] r_s [NUM_AXES];
    logic signed [MUL_W-1:0]    r_m [NUM_AXES];
    logic signed [ROW_W-1:0]    r_row;
    logic signed [ROW_W-1:0]    r_row4;
    logic signed [Q1_W-1:0]     r_q1;
    logic signed [Q2_W-1:0]     r_q2;
    logic signed [Q2_W-1:0]     r_q2_5;
    logic signed [QLO_W-1:0]    r_q3lo;
    logic signed [QHI_W-1:0]    r_q3hi;
    logic signed [T3_W-1:0]     r_t3;
    logic signed [ACC_W-1:0]    r_part;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [SAMPLE_W-1:0] r_value;
    logic                       r_clip;

    logic signed [DT3_LO:0]              w_dt3_lo;
    logic signed [DT3_W-DT3_LO-1:0]      w_dt3_hi;
    logic [QW-SAMPLE_W:0]                w_top;
    logic signed [QW-1:0]                w_q;
    logic                                w_over;

    // split dT^3 into an unsigned low and a signed high part
    assign w_dt3_lo = {1'b0, i_pows.dt3[DT3_LO-1:0]};
    assign w_dt3_hi = i_pows.dt3[DT3_W-1:DT3_LO];

    // stages 1 to 3: sample capture, matrix products, row sum
    always_ff @(posedge i_clk) begin
        r_s[0] <= i_smp.sample_x;
        r_s[1] <= i_smp.sample_y;
        r_s[2] <= i_smp.sample_z;
        for (int j = 0; j < NUM_AXES; j++) begin
            r_m[j] <= $signed(i_coef.row[j*COEFF_W +: COEFF_W]) * r_s[j];
        end
        r_row <= ROW_W'(r_m[0]) + ROW_W'(r_m[1]) + ROW_W'(r_m[2]);
    end

    // stage 4: temperature products
    always_ff @(posedge i_clk) begin
        r_row4 <= r_row;
        r_q1   <= i_coef.p1 * i_pows.dt;
        r_q2   <= i_coef.p2 * i_pows.dt2;
        r_q3lo <= i_coef.p3 * w_dt3_lo;
        r_q3hi <= i_coef.p3 * w_dt3_hi;
    end

    // stages 5 and 6: align to 32 fraction bits and accumulate
    always_ff @(posedge i_clk) begin
        r_part <= (ACC_W'(r_row4) <<< ROW_SH) - (ACC_W'(i_coef.off) <<< TOTAL_FRAC)
                  - (ACC_W'(r_q1) <<< P1_SH) + RND;
        r_q2_5 <= r_q2;
        r_t3   <= (T3_W'(r_q3hi) <<< DT3_LO) + T3_W'(r_q3lo);
        r_acc  <= r_part - (ACC_W'(r_q2_5) <<< P2_SH) - ACC_W'(r_t3);
    end

    // drop fraction bits and check the range
    assign w_q    = r_acc[ACC_W-1:TOTAL_FRAC];
    assign w_top  = w_q[QW-1:SAMPLE_W-1];
    assign w_over = !((&w_top) || (~|w_top));

    // stage 7: saturate
    always_ff @(posedge i_clk) begin
        r_clip <= w_over;
        if (w_over) begin
            r_value <= w_q[QW-1] ? SAT_MIN : SAT_MAX;
        end else begin
            r_value <= w_q[SAMPLE_W-1:0];
        end
    end

    assign o_res.value = r_value;
    assign o_res.clip  = r_clip;

endmodule
`default_nettype wire

/* rtl/imu_axis_calibration_top.sv */
// imu_axis_calibration_top: configuration registers, three axis lanes,
// shared temperature pipeline and the merging output stage
// depends on iac_pkg, iac_temp_pows and iac_lane
`timescale 1ns / 1ps
`default_nettype none

// Calibrates one three-axis sensor sample per clock: a transaction is taken
// whenever start is high (busy is always low), and its result appears on
// o_result with o_valid high for exactly one cycle, once the sample has passed
// the lane pipeline and the merging output register. Results are
// never held back, so the receiver must take every o_valid cycle. The rate of
// one transaction per cycle comes from the three axis lanes and the
// temperature power unit being fully pipelined, with a register after every
// multiplier. Registers are written through i_cfg_we,
// i_cfg_idx and i_cfg_data and must only change while no transaction is in
// flight; they take effect for transactions accepted afterwards.
module imu_axis_calibration_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  iac_pkg::t_cal_in                 i_sample,
    output logic                             o_valid,
    output iac_pkg::t_cal_out                o_result,
    input  wire logic                        i_cfg_we,
    input  wire logic [2:0]                  i_cfg_idx,
    input  wire logic [iac_pkg::CFG_W-1:0]   i_cfg_data
);
    import iac_pkg::*;

    localparam int PIPE_D = 7;

    logic [PACK_W-1:0]        r_scale_row [NUM_AXES];
    logic [PACK_W-1:0]        r_offset;
    logic [PACK_W-1:0]        r_poly_lin;
    logic [PACK_W-1:0]        r_poly_sq;
    logic [PACK_W-1:0]        r_poly_cube;
    logic signed [TEMP_W-1:0] r_ref_temp;
    logic [PIPE_D-1:0]        r_vpipe;
    logic                     r_valid;
    t_cal_out                 r_result;

    logic                     w_accept;
    t_temp_pows               w_pows;
    t_lane_coef               w_coef [NUM_AXES];
    t_lane_out                w_lane [NUM_AXES];

    // no stall anywhere in the pipeline
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_scale_row[i] <= SCALE_ONE << (i * COEFF_W);
            end
            r_offset    <= '0;
            r_poly_lin  <= '0;
            r_poly_sq   <= '0;
            r_poly_cube <= '0;
            r_ref_temp  <= REF_TEMP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SCALE_ROW_X: r_scale_row[0] <= i_cfg_data[PACK_W-1:0];
                REG_SCALE_ROW_Y: r_scale_row[1] <= i_cfg_data[PACK_W-1:0];
                REG_SCALE_ROW_Z: r_scale_row[2] <= i_cfg_data[PACK_W-1:0];
                REG_OFFSET:      r_offset       <= i_cfg_data[PACK_W-1:0];
                REG_POLY_LIN:    r_poly_lin     <= i_cfg_data[PACK_W-1:0];
                REG_POLY_SQ:     r_poly_sq      <= i_cfg_data[PACK_W-1:0];
                REG_POLY_CUBE:   r_poly_cube    <= i_cfg_data[PACK_W-1:0];
                REG_REF_TEMP:    r_ref_temp     <= i_cfg_data[TEMP_W-1:0];
                default:         r_ref_temp     <= r_ref_temp;
            endcase
        end
    end

    // per-axis coefficient slices
    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            w_coef[i].row = r_scale_row[i];
            w_coef[i].off = r_offset[i*COEFF_W +: COEFF_W];
            w_coef[i].p1  = r_poly_lin[i*COEFF_W +: COEFF_W];
            w_coef[i].p2  = r_poly_sq[i*COEFF_W +: COEFF_W];
            w_coef[i].p3  = r_poly_cube[i*COEFF_W +: COEFF_W];
        end
    end

    // shared temperature powers
    iac_temp_pows u_temp_pows (
        .i_clk      (i_clk),
        .i_temp     (i_sample.temperature),
        .i_ref_temp (r_ref_temp),
        .o_pows     (w_pows)
    );

    // one lane per axis
    for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
        iac_lane u_lane (
            .i_clk  (i_clk),
            .i_smp  (i_sample),
            .i_coef (w_coef[g]),
            .i_pows (w_pows),
            .o_res  (w_lane[g])
        );
    end

    // transaction valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vpipe <= '0;
            r_valid <= 1'b0;
        end else begin
            r_vpipe <= {r_vpipe[PIPE_D-2:0], w_accept};
            r_valid <= r_vpipe[PIPE_D-1];
        end
    end

    // merge lanes into the result
    always_ff @(posedge i_clk) begin
        r_result.corrected_x <= w_lane[0].value;
        r_result.corrected_y <= w_lane[1].value;
        r_result.corrected_z <= w_lane[2].value;
        r_result.saturated   <= w_lane[0].clip | w_lane[1].clip | w_lane[2].clip;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // every accepted transaction yields a result
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##8 o_valid)
        else $error("result missing eight cycles after accept");

    // no result without a matching earlier accept
    a_latency_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, 8))
        else $error("result without a matching accept");

    // saturation flag implies some axis sits on a bound
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.saturated) |->
            (o_result.corrected_x == SAT_MAX || o_result.corrected_x == SAT_MIN ||
             o_result.corrected_y == SAT_MAX || o_result.corrected_y == SAT_MIN ||
             o_result.corrected_z == SAT_MAX || o_result.corrected_z == SAT_MIN))
        else $error("saturated set with no axis at a bound");

endmodule
`default_nettype wire

/* tb/iac_cal_checker.sv */
// iac_cal_checker: watches the sample and result channels of the calibration block,
// mirrors its configuration registers, predicts each result and compares it
// depends on iac_pkg
`timescale 1ns / 1ps

module iac_cal_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  iac_pkg::t_cal_in            i_sample,
    input  logic                        i_valid,
    input  iac_pkg::t_cal_out           i_result,
    input  logic                        i_cfg_we,
    input  logic [2:0]                  i_cfg_idx,
    input  logic [iac_pkg::CFG_W-1:0]   i_cfg_data,
    output int                          o_pending,
    output int                          o_fail_count
);
    import iac_pkg::*;

    // register mirror
    logic [PACK_W-1:0] scale_rows [NUM_AXES];
    logic [PACK_W-1:0] offsets;
    logic [PACK_W-1:0] lin_coefs;
    logic [PACK_W-1:0] sq_coefs;
    logic [PACK_W-1:0] cube_coefs;
    logic [TEMP_W-1:0] ref_temp;

    // calibrated vectors still owed by the block, oldest first
    t_cal_out expected_cal_q [$];
    t_cal_out want;
    int       fail_cnt = 0;

    task automatic report_mismatch(string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        fail_cnt++;
    endtask

    // exact scale, offset and temperature polynomial, rounded half up, then clipped
    function automatic t_cal_out calibrate_sample(t_cal_in smp);
        logic signed [127:0] axis_in [NUM_AXES];
        logic signed [127:0] dt, dt2, dt3;
        logic signed [127:0] row_sum, c_off, c_lin, c_sq, c_cube, acc, rounded;
        logic [SAMPLE_W-1:0] val [NUM_AXES];
        logic                clip;
        t_cal_out            res;
        axis_in[0] = $signed(smp.sample_x);
        axis_in[1] = $signed(smp.sample_y);
        axis_in[2] = $signed(smp.sample_z);
        dt   = $signed(smp.temperature) - $signed(ref_temp);
        dt2  = dt * dt;
        dt3  = dt2 * dt;
        clip = 1'b0;
        for (int i = 0; i < NUM_AXES; i++) begin
            row_sum = '0;
            for (int j = 0; j < NUM_AXES; j++)
                row_sum = row_sum + $signed(scale_rows[i][j*COEFF_W +: COEFF_W]) * axis_in[j];
            c_off  = $signed(offsets[i*COEFF_W +: COEFF_W]);
            c_lin  = $signed(lin_coefs[i*COEFF_W +: COEFF_W]);
            c_sq   = $signed(sq_coefs[i*COEFF_W +: COEFF_W]);
            c_cube = $signed(cube_coefs[i*COEFF_W +: COEFF_W]);
            // everything aligned to TOTAL_FRAC fraction bits
            acc = (row_sum <<< (TOTAL_FRAC - SCALE_FRAC)) - (c_off <<< TOTAL_FRAC)
                - ((c_lin * dt) <<< P1_SH) - ((c_sq * dt2) <<< P2_SH) - c_cube * dt3;
            rounded = (acc + (128'sd1 <<< (TOTAL_FRAC - 1))) >>> TOTAL_FRAC;
            if (rounded > SAT_MAX) begin
                val[i] = SAT_MAX;
                clip   = 1'b1;
            end else if (rounded < SAT_MIN) begin
                val[i] = SAT_MIN;
                clip   = 1'b1;
            end else begin
                val[i] = rounded[SAMPLE_W-1:0];
            end
        end
        res.corrected_x = val[0];
        res.corrected_y = val[1];
        res.corrected_z = val[2];
        res.saturated   = clip;
        return res;
    endfunction

    // mirror writes, compare results, then queue the prediction for a new transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scale_rows[0] = SCALE_ONE;
            scale_rows[1] = SCALE_ONE << COEFF_W;
            scale_rows[2] = SCALE_ONE << (2 * COEFF_W);
            offsets       = '0;
            lin_coefs     = '0;
            sq_coefs      = '0;
            cube_coefs    = '0;
            ref_temp      = REF_TEMP_RST;
            expected_cal_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_SCALE_ROW_X: scale_rows[0] = i_cfg_data[PACK_W-1:0];
                    REG_SCALE_ROW_Y: scale_rows[1] = i_cfg_data[PACK_W-1:0];
                    REG_SCALE_ROW_Z: scale_rows[2] = i_cfg_data[PACK_W-1:0];
                    REG_OFFSET:      offsets       = i_cfg_data[PACK_W-1:0];
                    REG_POLY_LIN:    lin_coefs     = i_cfg_data[PACK_W-1:0];
                    REG_POLY_SQ:     sq_coefs      = i_cfg_data[PACK_W-1:0];
                    REG_POLY_CUBE:   cube_coefs    = i_cfg_data[PACK_W-1:0];
                    REG_REF_TEMP:    ref_temp      = i_cfg_data[TEMP_W-1:0];
                    default: ;
                endcase
            end
            if (i_valid) begin
                if (expected_cal_q.size() == 0) begin
                    report_mismatch($sformatf("result %h with no transaction pending",
                                              i_result));
                end else begin
                    want = expected_cal_q.pop_front();
                    if (i_result.corrected_x !== want.corrected_x)
                        report_mismatch($sformatf("corrected_x got %0d expected %0d",
                                                  i_result.corrected_x, want.corrected_x));
                    if (i_result.corrected_y !== want.corrected_y)
                        report_mismatch($sformatf("corrected_y got %0d expected %0d",
                                                  i_result.corrected_y, want.corrected_y));
                    if (i_result.corrected_z !== want.corrected_z)
                        report_mismatch($sformatf("corrected_z got %0d expected %0d",
                                                  i_result.corrected_z, want.corrected_z));
                    if (i_result.saturated !== want.saturated)
                        report_mismatch($sformatf("saturated got %b expected %b",
                                                  i_result.saturated, want.saturated));
                end
            end
            if (i_start && !i_busy)
                expected_cal_q.push_back(calibrate_sample(i_sample));
        end
        o_pending    <= expected_cal_q.size();
        o_fail_count <= fail_cnt;
    end

endmodule

/* tb/imu_axis_calibration_top_tb.sv */
// imu_axis_calibration_top_tb: clock, reset and stimulus for the calibration block
// directed corner cases, then random phases with changing registers and sender gaps
// depends on iac_pkg, imu_axis_calibration_top and iac_cal_checker
`timescale 1ns / 1ps

module imu_axis_calibration_top_tb;
    import iac_pkg::*;

    localparam int CYCLE_LIMIT     = 200_000;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int END_SLACK       = 20;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               cal_start  = 1'b0;
    logic               cal_busy;
    t_cal_in            sample_bus = '0;
    logic               res_valid;
    t_cal_out           result_bus;
    logic               cfg_we     = 1'b0;
    logic [2:0]         cfg_idx    = '0;
    logic [CFG_W-1:0]   cfg_data   = '0;
    int                 pending;
    int                 fail_count;
    int                 cycle_cnt  = 0;
    int                 idle_pct   = 0;
    logic [TEMP_W-1:0]  cur_tref   = REF_TEMP_RST;

    always #5 i_clk = ~i_clk;

    imu_axis_calibration_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (cal_start),
        .busy       (cal_busy),
        .i_sample   (sample_bus),
        .o_valid    (res_valid),
        .o_result   (result_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    iac_cal_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (cal_start),
        .i_busy       (cal_busy),
        .i_sample     (sample_bus),
        .i_valid      (res_valid),
        .i_result     (result_bus),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [CFG_W-1:0] pack3(logic [15:0] fx, logic [15:0] fy,
                                              logic [15:0] fz);
        return {fz, fy, fx};
    endfunction

    function automatic logic [15:0] rand_between(int lo, int hi);
        return 16'(lo + int'($urandom_range(hi - lo)));
    endfunction

    function automatic logic [CFG_W-1:0] rand_word();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[CFG_W-1:0];
    endfunction

    // one coefficient: realistic range, any value, or a corner value
    function automatic logic [15:0] coef_field(int mode, int lo, int hi);
        case (mode)
            0: return rand_between(lo, hi);
            1: return 16'($urandom);
            default: begin
                case ($urandom_range(3))
                    0: return 16'h7FFF;
                    1: return 16'h8000;
                    2: return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
        endcase
    endfunction

    // all tasks are entered just after a rising edge
    task automatic write_reg(t_reg_idx idx, logic [CFG_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic load_config(logic [CFG_W-1:0] rx, logic [CFG_W-1:0] ry,
                               logic [CFG_W-1:0] rz, logic [CFG_W-1:0] off,
                               logic [CFG_W-1:0] lin, logic [CFG_W-1:0] sq,
                               logic [CFG_W-1:0] cube, logic [CFG_W-1:0] tref);
        write_reg(REG_SCALE_ROW_X, rx);
        write_reg(REG_SCALE_ROW_Y, ry);
        write_reg(REG_SCALE_ROW_Z, rz);
        write_reg(REG_OFFSET, off);
        write_reg(REG_POLY_LIN, lin);
        write_reg(REG_POLY_SQ, sq);
        write_reg(REG_POLY_CUBE, cube);
        write_reg(REG_REF_TEMP, tref);
        cfg_we   <= 1'b0;
        cur_tref  = tref[TEMP_W-1:0];
        @(posedge i_clk);
    endtask

    // near-identity calibration, fully random words, or corner values
    task automatic random_config(int mode);
        logic [CFG_W-1:0] rows [NUM_AXES];
        logic [CFG_W-1:0] off, lin, sq, cube, tref;
        for (int i = 0; i < NUM_AXES; i++)
            for (int j = 0; j < NUM_AXES; j++)
                rows[i][16*j +: 16] = (i == j) ? coef_field(mode, 14384, 18384)
                                               : coef_field(mode, -600, 600);
        for (int i = 0; i < NUM_AXES; i++) begin
            off[16*i +: 16]  = coef_field(mode, -3000, 3000);
            lin[16*i +: 16]  = coef_field(mode, -2000, 2000);
            sq[16*i +: 16]   = coef_field(mode, -100, 100);
            cube[16*i +: 16] = coef_field(mode, -4, 4);
        end
        // upper bits of the reference temperature write are junk on purpose
        tref = rand_word();
        tref[15:0] = coef_field(mode, -10240, 21760);
        load_config(rows[0], rows[1], rows[2], off, lin, sq, cube, tref);
    endtask

    // offer one transaction after a random gap and hold it until taken
    task automatic send_sample(logic [15:0] sx, logic [15:0] sy, logic [15:0] sz,
                               logic [15:0] temp);
        while ($urandom_range(99) < idle_pct) begin
            cal_start <= 1'b0;
            @(posedge i_clk);
        end
        cal_start  <= 1'b1;
        sample_bus <= {temp, sz, sy, sx};
        do @(posedge i_clk); while (cal_busy);
    endtask

    task automatic send_random_sample();
        logic [15:0] ax [NUM_AXES];
        logic [15:0] temp;
        for (int k = 0; k < NUM_AXES; k++)
            ax[k] = ($urandom_range(9) < 7) ? 16'($urandom) : rand_between(-2048, 2047);
        temp = ($urandom_range(1) == 1) ? 16'($urandom)
                                        : 16'(cur_tref + rand_between(-5120, 5120));
        send_sample(ax[0], ax[1], ax[2], temp);
    endtask

    // stop offering and wait until every owed result has come back
    task automatic drain();
        cal_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset registers, extremes of every field
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'd6400);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd6400);
        send_sample(16'h8000, 16'h8000, 16'h8000, 16'd6400);
        send_sample(16'h7FFF, 16'h8000, 16'h0001, 16'h7FFF);
        send_sample(16'h8000, 16'h7FFF, 16'hFFFF, 16'h8000);
        send_sample(16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0);

        // directed: half scale for ties, near +2 and -2 scale for clipping
        drain();
        load_config(pack3(16'd8192, 16'h0000, 16'h0000),
                    pack3(16'h0000, 16'h7FFF, 16'h0000),
                    pack3(16'h0000, 16'h0000, 16'h8000),
                    '0, '0, '0, '0, '0);
        send_sample(16'h0001, 16'h0001, 16'h0001, 16'h0000);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_sample(16'h0003, 16'h0003, 16'h0003, 16'h0000);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000);
        send_sample(16'h8000, 16'h8000, 16'h8000, 16'h0000);

        // directed: extreme offsets and polynomial, widest temperature delta
        drain();
        load_config(pack3(16'h4000, 16'h0000, 16'h0000),
                    pack3(16'h0000, 16'h4000, 16'h0000),
                    pack3(16'h0000, 16'h0000, 16'h4000),
                    pack3(16'h7FFF, 16'h8000, 16'h0001),
                    pack3(16'h7FFF, 16'h8000, 16'h0001),
                    pack3(16'h8000, 16'h7FFF, 16'hFFFF),
                    pack3(16'h7FFF, 16'h8000, 16'h0001),
                    {32'h0000_0000, 16'h8000});
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h7FFF);
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h8000);
        send_sample(16'h7FFF, 16'h8000, 16'h0000, 16'h0000);

        // directed: same, reference at the top so the delta is most negative
        drain();
        load_config(pack3(16'h4000, 16'h0000, 16'h0000),
                    pack3(16'h0000, 16'h4000, 16'h0000),
                    pack3(16'h0000, 16'h0000, 16'h4000),
                    pack3(16'h7FFF, 16'h8000, 16'h0001),
                    pack3(16'h7FFF, 16'h8000, 16'h0001),
                    pack3(16'h8000, 16'h7FFF, 16'hFFFF),
                    pack3(16'h7FFF, 16'h8000, 16'h0001),
                    {32'hFFFF_FFFF, 16'h7FFF});
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h8000);
        send_sample(16'h8000, 16'h7FFF, 16'h0001, 16'h7FFF);

        // random phases, each with fresh registers and a gap rate chosen for it
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            random_config((ph == 3) ? 1 : (ph == 6) ? 2 : 0);
            case (ph % 4)
                1:       idle_pct = 69;
                3:       idle_pct = 28;
                default: idle_pct = 0;
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 2 && n == 60)
                    drain();
                send_random_sample();
            end
        end

        drain();
        repeat (END_SLACK) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/iac_pkg.sv
rtl/iac_temp_pows.sv
rtl/iac_lane.sv
rtl/imu_axis_calibration_top.sv
tb/iac_cal_checker.sv
tb/imu_axis_calibration_top_tb.sv
